[design/assert_macros.svh]
// Assertion macros shared by the breathing fade sequencer RTL.
// No dependencies; the SYNTHESIS define turns every macro into nothing.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// clocked check that is ignored while reset is high
`define BFS_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("%m: check failed");
// clocked check that also holds during reset
`define BFS_ASSERT_ALWAYS(label, clk, prop) \
   label: assert property (@(posedge clk) prop) \
      else $error("%m: check failed");
`else
`define BFS_ASSERT(label, clk, rst, prop)
`define BFS_ASSERT_ALWAYS(label, clk, prop)
`endif
`endif

[design/bfs_pkg.sv]
// Shared types and constants of the breathing fade sequencer.
// No dependencies; used by every module of the block.
package bfs_pkg;

   localparam int TICK_MS = 10;

   localparam int CNT_W   = 13;
   localparam int LEVEL_W = 8;
   localparam int NUM_W   = 10;
   localparam int PROD_W  = LEVEL_W + NUM_W;
   localparam int SAMPLE_W = 10;
   localparam int NUM_COLORS = 3;

   localparam logic [CNT_W-1:0] CNT_MAX       = '1;
   localparam logic [CNT_W-1:0] RAMP_MS       = 13'd1000;
   localparam logic [CNT_W-1:0] ACTIVE_MS     = 13'd3000;
   localparam logic [CNT_W-1:0] PERIOD_MAX_MS = 13'd6000;
   localparam logic [CNT_W-1:0] PERIOD_RESET  = 13'd3000;

   // sample * 3000, then / 1023 by reciprocal (exact for the sample range)
   localparam int SCALED_W = 22;
   localparam logic [11:0] PERIOD_SPAN_MS = 12'd3000;
   localparam int RECIP_1023_W = 23;
   localparam logic [RECIP_1023_W-1:0] RECIP_1023 = 23'd4198405;
   localparam int RECIP_1023_SHIFT = 32;

   // x / 1000 by reciprocal, exact for x up to 255 * 1000
   localparam int RECIP_1000_W = 19;
   localparam logic [RECIP_1000_W-1:0] RECIP_1000 = 19'd268436;
   localparam int RECIP_1000_SHIFT = 28;

   localparam logic [LEVEL_W-1:0] LEVEL_RESET = 8'd50;

   localparam int CSR_IDX_W = 2;
   localparam logic [CSR_IDX_W-1:0] CSR_RED   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_GREEN = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_BLUE  = 2'd2;

   typedef enum logic [1:0] {
      PH_RISE = 2'd0,
      PH_HOLD = 2'd1,
      PH_FALL = 2'd2,
      PH_OFF  = 2'd3
   } phase_type;

   typedef logic [NUM_COLORS-1:0][LEVEL_W-1:0] color_type;

   // what the sequencer hands to the drive scaler for one request
   typedef struct packed {
      logic             upd;
      logic [NUM_W-1:0] num;
      phase_type        phase;
   } ctrl_type;

endpackage

[design/rgb_breathing_fade_sequencer.sv]
// Top level of the RGB breathing fade sequencer: handshake, CSRs, stage valids.
// Depends on bfs_pkg, bfs_reload_calc, bfs_phase_seq, bfs_drive_scale, assert_macros.svh.
//
//   channel   direction   handshake              payload
//   req       in          req_valid / req_stall  req_light_sample
//   rsp       out         rsp_valid / rsp_stall  rsp_red/green/blue_drive, rsp_phase_now
//   csr       in          csr_write_en           csr_index, csr_wdata
//
// One request per cycle while rsp_stall is low; each request passes the stages scale,
// reload quotient, phase step, level product and divide by 1000 to its response.
// The phase step and the drive register are the only loops.
// Reset is synchronous; afterwards requests are taken at once.
// Each stage holds only while the one after it is full and held, so a request is
// still taken while a response waits on rsp_stall, until all five stages fill.
`include "assert_macros.svh"
module rgb_breathing_fade_sequencer #(
   parameter int TICK_MS = bfs_pkg::TICK_MS
) (
   input  logic                              clock,
   input  logic                              reset,

   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic [bfs_pkg::SAMPLE_W-1:0]      req_light_sample,

   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic [bfs_pkg::LEVEL_W-1:0]       rsp_red_drive,
   output logic [bfs_pkg::LEVEL_W-1:0]       rsp_green_drive,
   output logic [bfs_pkg::LEVEL_W-1:0]       rsp_blue_drive,
   output logic [1:0]                        rsp_phase_now,

   input  logic                              csr_write_en,
   input  logic [bfs_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [bfs_pkg::LEVEL_W-1:0]       csr_wdata
);

   localparam int STAGES = 5;

   logic [STAGES-1:0]         valid_ff, valid_in;
   logic [STAGES-1:0]         ready;
   logic [STAGES-1:0]         load;
   bfs_pkg::color_type        level_ff;
   logic [bfs_pkg::CNT_W-1:0] reload;
   bfs_pkg::ctrl_type         ctrl;
   bfs_pkg::color_type        drive;
   bfs_pkg::phase_type        phase;

   always_comb begin
      ready[STAGES-1] = !valid_ff[STAGES-1] || !rsp_stall;
      for (int k = STAGES - 2; k >= 0; k--) begin
         ready[k] = !valid_ff[k] || ready[k+1];
      end
      load[0]     = ready[0] && req_valid;
      valid_in[0] = ready[0] ? req_valid : valid_ff[0];
      for (int k = 1; k < STAGES; k++) begin
         load[k]     = ready[k] && valid_ff[k-1];
         valid_in[k] = ready[k] ? valid_ff[k-1] : valid_ff[k];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         level_ff <= {bfs_pkg::LEVEL_RESET, bfs_pkg::LEVEL_RESET, bfs_pkg::LEVEL_RESET};
      end else if (csr_write_en) begin
         unique case (csr_index)
            bfs_pkg::CSR_RED:   level_ff[0] <= csr_wdata;
            bfs_pkg::CSR_GREEN: level_ff[1] <= csr_wdata;
            bfs_pkg::CSR_BLUE:  level_ff[2] <= csr_wdata;
            default: ;
         endcase
      end
   end

   bfs_reload_calc u_reload (
      .clock      (clock),
      .load_scale (load[0]),
      .load_quot  (load[1]),
      .sample     (req_light_sample),
      .reload     (reload)
   );

   bfs_phase_seq #(
      .TICK_MS (TICK_MS)
   ) u_seq (
      .clock  (clock),
      .reset  (reset),
      .step   (load[2]),
      .reload (reload),
      .ctrl   (ctrl)
   );

   bfs_drive_scale u_scale (
      .clock      (clock),
      .reset      (reset),
      .load_prod  (load[3]),
      .load_drive (load[4]),
      .level      (level_ff),
      .ctrl       (ctrl),
      .drive      (drive),
      .phase      (phase)
   );

   assign req_stall       = !ready[0];
   assign rsp_valid       = valid_ff[STAGES-1];
   assign rsp_red_drive   = drive[0];
   assign rsp_green_drive = drive[1];
   assign rsp_blue_drive  = drive[2];
   assign rsp_phase_now   = phase;

   `BFS_ASSERT(a_stall_only_when_full, clock, reset, req_stall |-> ((&valid_ff) && rsp_stall))
   `BFS_ASSERT(a_held_stage_kept, clock, reset, (valid_ff[STAGES-2] && !ready[STAGES-1]) |=> valid_ff[STAGES-2])
   `BFS_ASSERT_ALWAYS(a_reset_empties, clock, reset |=> (valid_ff == '0))

endmodule

[design/bfs_reload_calc.sv]
// Period reload value 6000 - sample*3000/1023, two register stages.
// Depends on bfs_pkg.
module bfs_reload_calc (
   input  logic                               clock,
   input  logic                               load_scale,
   input  logic                               load_quot,
   input  logic [bfs_pkg::SAMPLE_W-1:0]       sample,
   output logic [bfs_pkg::CNT_W-1:0]          reload
);

   localparam int MUL_W = bfs_pkg::SCALED_W + bfs_pkg::RECIP_1023_W;

   logic [bfs_pkg::SCALED_W-1:0] scaled_ff;
   logic [bfs_pkg::SCALED_W-1:0] scaled_in;
   logic [bfs_pkg::CNT_W-1:0]    reload_ff;
   logic [bfs_pkg::CNT_W-1:0]    reload_in;
   logic [MUL_W-1:0]             recip_prod;

   always_comb begin
      scaled_in  = bfs_pkg::SCALED_W'(sample) * bfs_pkg::SCALED_W'(bfs_pkg::PERIOD_SPAN_MS);
      recip_prod = MUL_W'(scaled_ff) * MUL_W'(bfs_pkg::RECIP_1023);
      // quotient is at most 3000, fits in the counter width
      reload_in  = bfs_pkg::PERIOD_MAX_MS -
                   recip_prod[bfs_pkg::RECIP_1023_SHIFT +: bfs_pkg::CNT_W];
   end

   always_ff @(posedge clock) begin
      if (load_scale) begin
         scaled_ff <= scaled_in;
      end
      if (load_quot) begin
         reload_ff <= reload_in;
      end
   end

   assign reload = reload_ff;

endmodule

[design/bfs_phase_seq.sv]
// Breathing phase sequencer: phase, per-phase and period timers, ramp numerator.
// Depends on bfs_pkg and assert_macros.svh.
`include "assert_macros.svh"
module bfs_phase_seq #(
   parameter int TICK_MS = bfs_pkg::TICK_MS
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      step,
   input  logic [bfs_pkg::CNT_W-1:0] reload,
   output bfs_pkg::ctrl_type         ctrl
);

   localparam int SUM_W = bfs_pkg::CNT_W + 1;

   bfs_pkg::phase_type        phase_ff, phase_in;
   logic [bfs_pkg::CNT_W-1:0] phase_ms_ff, phase_ms_in;
   logic [bfs_pkg::CNT_W-1:0] period_ms_ff, period_ms_in;
   logic [bfs_pkg::CNT_W-1:0] cycle_ms_ff, cycle_ms_in;
   bfs_pkg::ctrl_type         ctrl_ff, ctrl_in;

   logic [SUM_W-1:0]          t_sum;
   logic [SUM_W-1:0]          p_sum;
   logic [bfs_pkg::CNT_W-1:0] t_ms;
   logic [bfs_pkg::CNT_W-1:0] p_ms;
   logic [bfs_pkg::CNT_W-1:0] off_ms;
   logic [bfs_pkg::CNT_W-1:0] fall_num;

   always_comb begin
      t_sum    = {1'b0, phase_ms_ff} + SUM_W'(TICK_MS);
      t_ms     = t_sum[bfs_pkg::CNT_W] ? bfs_pkg::CNT_MAX : t_sum[bfs_pkg::CNT_W-1:0];
      p_sum    = {1'b0, period_ms_ff} + SUM_W'(TICK_MS);
      p_ms     = p_sum[bfs_pkg::CNT_W] ? bfs_pkg::CNT_MAX : p_sum[bfs_pkg::CNT_W-1:0];
      off_ms   = (cycle_ms_ff > bfs_pkg::ACTIVE_MS) ? cycle_ms_ff - bfs_pkg::ACTIVE_MS : '0;
      fall_num = bfs_pkg::RAMP_MS - t_ms;

      phase_in      = phase_ff;
      phase_ms_in   = t_ms;
      ctrl_in.upd   = 1'b0;
      ctrl_in.num   = '0;

      unique case (phase_ff)
         bfs_pkg::PH_RISE: begin
            ctrl_in.num = t_ms[bfs_pkg::NUM_W-1:0];
         end
         bfs_pkg::PH_HOLD: begin
            ctrl_in.num = bfs_pkg::RAMP_MS[bfs_pkg::NUM_W-1:0];
         end
         bfs_pkg::PH_FALL: begin
            ctrl_in.num = fall_num[bfs_pkg::NUM_W-1:0];
         end
         bfs_pkg::PH_OFF: begin
            ctrl_in.num = '0;
         end
         default: begin
            ctrl_in.num = '0;
         end
      endcase

      if (phase_ff == bfs_pkg::PH_OFF) begin
         ctrl_in.upd = 1'b1;
         if (t_ms >= off_ms) begin
            phase_in    = bfs_pkg::PH_RISE;
            phase_ms_in = '0;
         end
      end else if (t_ms <= bfs_pkg::RAMP_MS) begin
         ctrl_in.upd = 1'b1;
      end else begin
         // phase change: drive keeps its previous value
         phase_in    = bfs_pkg::phase_type'(phase_ff + 2'd1);
         phase_ms_in = '0;
      end
      ctrl_in.phase = phase_in;

      // the off phase above uses the period from before this reload
      if (p_ms >= cycle_ms_ff) begin
         period_ms_in = '0;
         cycle_ms_in  = reload;
      end else begin
         period_ms_in = p_ms;
         cycle_ms_in  = cycle_ms_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= bfs_pkg::PH_RISE;
         phase_ms_ff  <= '0;
         period_ms_ff <= '0;
         cycle_ms_ff  <= bfs_pkg::PERIOD_RESET;
      end else if (step) begin
         phase_ff     <= phase_in;
         phase_ms_ff  <= phase_ms_in;
         period_ms_ff <= period_ms_in;
         cycle_ms_ff  <= cycle_ms_in;
      end
   end

   always_ff @(posedge clock) begin
      if (step) begin
         ctrl_ff <= ctrl_in;
      end
   end

   assign ctrl = ctrl_ff;

   `BFS_ASSERT(a_ramp_time_bound, clock, reset, (phase_ff != bfs_pkg::PH_OFF) |-> (phase_ms_ff <= bfs_pkg::RAMP_MS))
   `BFS_ASSERT(a_period_below_cycle, clock, reset, period_ms_ff < cycle_ms_ff)
   `BFS_ASSERT(a_idle_holds_state, clock, reset, !step |=> ($stable(phase_ff) && $stable(cycle_ms_ff)))

endmodule

[design/bfs_drive_scale.sv]
// Drive scaler: level*num in one stage, /1000 by reciprocal into the drive register.
// Depends on bfs_pkg.
module bfs_drive_scale (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 load_prod,
   input  logic                                 load_drive,
   input  bfs_pkg::color_type                   level,
   input  bfs_pkg::ctrl_type                    ctrl,
   output bfs_pkg::color_type                   drive,
   output bfs_pkg::phase_type                   phase
);

   localparam int MUL_W = bfs_pkg::PROD_W + bfs_pkg::RECIP_1000_W;

   logic [bfs_pkg::NUM_COLORS-1:0][bfs_pkg::PROD_W-1:0] prod_ff, prod_in;
   logic                  upd_ff;
   bfs_pkg::phase_type    phase_b_ff;
   bfs_pkg::color_type    drive_ff, drive_in;
   bfs_pkg::phase_type    phase_ff;
   logic [bfs_pkg::NUM_COLORS-1:0][MUL_W-1:0] recip_prod;

   always_comb begin
      for (int c = 0; c < bfs_pkg::NUM_COLORS; c++) begin
         prod_in[c]    = bfs_pkg::PROD_W'(level[c]) * bfs_pkg::PROD_W'(ctrl.num);
         recip_prod[c] = MUL_W'(prod_ff[c]) * MUL_W'(bfs_pkg::RECIP_1000);
         drive_in[c]   = upd_ff ?
                         recip_prod[c][bfs_pkg::RECIP_1000_SHIFT +: bfs_pkg::LEVEL_W] :
                         drive_ff[c];
      end
   end

   always_ff @(posedge clock) begin
      if (load_prod) begin
         prod_ff    <= prod_in;
         upd_ff     <= ctrl.upd;
         phase_b_ff <= ctrl.phase;
      end
      if (load_drive) begin
         phase_ff <= phase_b_ff;
      end
   end

   // the drive register is block state: it survives phase changes
   always_ff @(posedge clock) begin
      if (reset) begin
         drive_ff <= {8'd0, 8'd255, 8'd0};
      end else if (load_drive) begin
         drive_ff <= drive_in;
      end
   end

   assign drive = drive_ff;
   assign phase = phase_ff;

endmodule

[dv/rgb_breathing_fade_sequencer_tb.sv]
// Self-checking testbench for rgb_breathing_fade_sequencer: random ticks, CSR settings, stalls.
// Depends on bfs_pkg and the RTL top; responses are checked against an in-bench predictor.
`timescale 1ns / 100ps
module rgb_breathing_fade_sequencer_tb;

   localparam int RAMP          = 1000;
   localparam int ACTIVE        = 3000;
   localparam int PERIOD_TOP    = 6000;
   localparam int PERIOD_SPAN   = 3000;
   localparam int SENSOR_TOP    = 1023;
   localparam int SAT_MS        = 8191;
   localparam int SEGMENTS      = 6;
   localparam int SEG_ITEMS     = 180;
   localparam int WATCHDOG_MAX  = 1000;
   localparam logic [bfs_pkg::CSR_IDX_W-1:0] CSR_UNUSED = 2'd3;

   typedef struct {
      logic [bfs_pkg::LEVEL_W-1:0] red;
      logic [bfs_pkg::LEVEL_W-1:0] green;
      logic [bfs_pkg::LEVEL_W-1:0] blue;
      bfs_pkg::phase_type          phase;
   } shade_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic [bfs_pkg::SAMPLE_W-1:0] req_light_sample = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic [bfs_pkg::LEVEL_W-1:0] rsp_red_drive;
   logic [bfs_pkg::LEVEL_W-1:0] rsp_green_drive;
   logic [bfs_pkg::LEVEL_W-1:0] rsp_blue_drive;
   logic [1:0] rsp_phase_now;
   logic csr_write_en = 1'b0;
   logic [bfs_pkg::CSR_IDX_W-1:0] csr_index = '0;
   logic [bfs_pkg::LEVEL_W-1:0] csr_wdata = '0;

   rgb_breathing_fade_sequencer u_dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_light_sample(req_light_sample),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_red_drive   (rsp_red_drive),
      .rsp_green_drive (rsp_green_drive),
      .rsp_blue_drive  (rsp_blue_drive),
      .rsp_phase_now   (rsp_phase_now),
      .csr_write_en    (csr_write_en),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata)
   );

   always #1 clock = ~clock;

   logic [bfs_pkg::SAMPLE_W-1:0] light_queue[$];
   shade_type shade_queue[$];
   int errors = 0;
   int quiet_cycles = 0;
   int req_gap = 0;
   int stall_left = 0;
   bit idle_on = 1'b1;
   logic req_fired = 1'b0;

   // predictor state
   int peak[3];
   int drive[3];
   bfs_pkg::phase_type ph;
   int ph_ms;
   int per_ms;
   int period_ms;

   function automatic int sat_ms(input int v);
      return (v > SAT_MS) ? SAT_MS : v;
   endfunction

   task automatic scale_drive(input int num);
      for (int c = 0; c < 3; c++) drive[c] = (peak[c] * num) / RAMP;
   endtask

   task automatic breathe_tick(input logic [bfs_pkg::SAMPLE_W-1:0] sample,
                               output shade_type s);
      int t;
      int off_ms;
      t = sat_ms(ph_ms + bfs_pkg::TICK_MS);
      case (ph)
         bfs_pkg::PH_RISE: begin
            if (t <= RAMP) begin
               scale_drive(t);
               ph_ms = t;
            end else begin
               ph = bfs_pkg::PH_HOLD;
               ph_ms = 0;
            end
         end
         bfs_pkg::PH_HOLD: begin
            if (t <= RAMP) begin
               scale_drive(RAMP);
               ph_ms = t;
            end else begin
               ph = bfs_pkg::PH_FALL;
               ph_ms = 0;
            end
         end
         bfs_pkg::PH_FALL: begin
            if (t <= RAMP) begin
               scale_drive(RAMP - t);
               ph_ms = t;
            end else begin
               ph = bfs_pkg::PH_OFF;
               ph_ms = 0;
            end
         end
         default: begin
            drive = '{0, 0, 0};
            off_ms = (period_ms > ACTIVE) ? period_ms - ACTIVE : 0;
            if (t >= off_ms) begin
               ph = bfs_pkg::PH_RISE;
               ph_ms = 0;
            end else begin
               ph_ms = t;
            end
         end
      endcase
      // off phase above still saw the old period
      per_ms = sat_ms(per_ms + bfs_pkg::TICK_MS);
      if (per_ms >= period_ms) begin
         per_ms = 0;
         period_ms = PERIOD_TOP - (int'(sample) * PERIOD_SPAN) / SENSOR_TOP;
      end
      s.red   = bfs_pkg::LEVEL_W'(drive[0]);
      s.green = bfs_pkg::LEVEL_W'(drive[1]);
      s.blue  = bfs_pkg::LEVEL_W'(drive[2]);
      s.phase = ph;
   endtask

   task automatic report_mismatch(input string what, input int got, input int want);
      $display("ERROR @%0t: %s got %0d want %0d", $realtime, what, got, want);
      errors++;
   endtask

   task automatic check_field(input string what, input int got, input int want);
      if (got != want) report_mismatch(what, got, want);
   endtask

   // leaves csr_write_en high; caller lowers it after the last write
   task automatic set_peak(input logic [bfs_pkg::CSR_IDX_W-1:0] idx,
                           input logic [bfs_pkg::LEVEL_W-1:0] v);
      @(negedge clock);
      csr_write_en <= 1'b1;
      csr_index    <= idx;
      csr_wdata    <= v;
      if (idx == bfs_pkg::CSR_RED) peak[0] = v;
      else if (idx == bfs_pkg::CSR_GREEN) peak[1] = v;
      else if (idx == bfs_pkg::CSR_BLUE) peak[2] = v;
   endtask

   task automatic wait_idle();
      while (light_queue.size() != 0 || req_valid || shade_queue.size() != 0)
         @(posedge clock);
   endtask

   // request driver
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_fired) begin
         if (req_gap > 0) begin
            req_valid <= 1'b0;
            req_gap--;
         end else if (idle_on && $urandom_range(0, 7) == 0) begin
            req_valid <= 1'b0;
            req_gap = $urandom_range(0, 9);
         end else if (light_queue.size() > 0) begin
            req_light_sample <= light_queue.pop_front();
            req_valid <= 1'b1;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // response back-pressure
   always @(negedge clock) begin
      if (stall_left > 0) begin
         rsp_stall <= 1'b1;
         stall_left--;
      end else if (idle_on && $urandom_range(0, 7) == 0) begin
         rsp_stall <= 1'b1;
         stall_left = $urandom_range(0, 9);
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   // monitor, predictor hookup and watchdog
   always @(posedge clock) begin
      shade_type s;
      shade_type want;
      if (reset) begin
         req_fired <= 1'b0;
      end else begin
         req_fired <= req_valid && !req_stall;
         if (req_valid && !req_stall) begin
            breathe_tick(req_light_sample, s);
            shade_queue.push_back(s);
         end
         if (rsp_valid && !rsp_stall) begin
            if (shade_queue.size() == 0) begin
               report_mismatch("unexpected response, phase", int'(rsp_phase_now), -1);
            end else begin
               want = shade_queue.pop_front();
               check_field("red_drive", int'(rsp_red_drive), int'(want.red));
               check_field("green_drive", int'(rsp_green_drive), int'(want.green));
               check_field("blue_drive", int'(rsp_blue_drive), int'(want.blue));
               check_field("phase_now", int'(rsp_phase_now), int'(want.phase));
            end
         end
      end
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_MAX) begin
         $display("watchdog: no handshake for %0d cycles", quiet_cycles);
         $display("rgb_breathing_fade_sequencer: mismatch");
         $finish;
      end
   end

   initial begin
      logic [bfs_pkg::SAMPLE_W-1:0] directed[8];
      logic [bfs_pkg::SAMPLE_W-1:0] v;
      directed = '{10'h000, 10'h3FF, 10'h155, 10'h2AA, 10'h001, 10'h3FE, 10'h200, 10'h1FF};
      peak = '{50, 50, 50};
      drive = '{0, 255, 0};
      ph = bfs_pkg::PH_RISE;
      ph_ms = 0;
      per_ms = 0;
      period_ms = 3000;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed: sensor extremes and their neighbours, alternating bit patterns and mid-scale values at reset levels
      foreach (directed[i]) light_queue.push_back(directed[i]);
      repeat (12) light_queue.push_back(bfs_pkg::SAMPLE_W'($urandom_range(0, SENSOR_TOP)));

      for (int seg = 0; seg < SEGMENTS; seg++) begin
         wait_idle();
         case (seg)
            0: begin
               set_peak(bfs_pkg::CSR_RED, 8'hFF);
               set_peak(bfs_pkg::CSR_GREEN, 8'hFF);
               set_peak(bfs_pkg::CSR_BLUE, 8'hFF);
            end
            1: begin
               set_peak(bfs_pkg::CSR_RED, 8'h00);
               set_peak(bfs_pkg::CSR_GREEN, 8'h00);
               set_peak(bfs_pkg::CSR_BLUE, 8'h00);
            end
            2: begin
               set_peak(bfs_pkg::CSR_RED, 8'hFF);
               set_peak(bfs_pkg::CSR_GREEN, 8'h00);
               set_peak(bfs_pkg::CSR_BLUE, 8'h80);
            end
            5: begin
               // unused index must leave all peaks alone
               set_peak(CSR_UNUSED, 8'hA5);
               set_peak(bfs_pkg::CSR_RED, 8'h01);
               set_peak(bfs_pkg::CSR_GREEN, 8'hFE);
               set_peak(CSR_UNUSED, 8'h5A);
            end
            default: begin
               set_peak(bfs_pkg::CSR_RED, bfs_pkg::LEVEL_W'($urandom_range(0, 255)));
               set_peak(bfs_pkg::CSR_GREEN, bfs_pkg::LEVEL_W'($urandom_range(0, 255)));
               set_peak(bfs_pkg::CSR_BLUE, bfs_pkg::LEVEL_W'($urandom_range(0, 255)));
            end
         endcase
         @(negedge clock);
         csr_write_en <= 1'b0;
         @(posedge clock);
         idle_on = (seg != 2) && (seg != SEGMENTS - 1);
         for (int i = 0; i < SEG_ITEMS; i++) begin
            if ($urandom_range(0, 3) == 0)
               v = $urandom_range(0, 1) ? 10'h3FF : 10'h000;
            else
               v = bfs_pkg::SAMPLE_W'($urandom_range(0, SENSOR_TOP));
            light_queue.push_back(v);
         end
      end

      wait_idle();
      repeat (20) @(posedge clock);
      if (errors == 0) $display("rgb_breathing_fade_sequencer: match");
      else $display("rgb_breathing_fade_sequencer: mismatch");
      $finish;
   end

endmodule

[rgb_breathing_fade_sequencer.f]
+incdir+design
design/bfs_pkg.sv
design/bfs_reload_calc.sv
design/bfs_phase_seq.sv
design/bfs_drive_scale.sv
design/rgb_breathing_fade_sequencer.sv
dv/rgb_breathing_fade_sequencer_tb.sv
